/* src/arpc_pkg.sv */
// ============================================================================
// arpc_pkg
// Shared constants and types for the ARP cache table: table geometry,
// controller states and the command and status groups between the controller
// and the datapath.
// ============================================================================
package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

/* src/arpc_ctrl.sv */
// ============================================================================
// arpc_ctrl
// Controller for the ARP cache table: takes a request beat, steps the table
// scan until a match or the end of the filled slots, then commits the result.
// ============================================================================
module arpc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  arpc_pkg::sts_t sts,
    output arpc_pkg::cmd_t cmd
);

    arpc_pkg::state_t state_reg;
    arpc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = arpc_pkg::ST_SCAN;
                end
            end
            arpc_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match || sts.scan_done)
                begin
                    state_next = arpc_pkg::ST_FIN;
                end
            end
            arpc_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = arpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/arpc_dp.sv */
// ============================================================================
// arpc_dp
// Datapath for the ARP cache table: request registers, entry memory with a
// registered read port, compare stage, fill count and the result register.
// ============================================================================
module arpc_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  arpc_pkg::cmd_t                 cmd,
    output arpc_pkg::sts_t                 sts,
    input  logic                           opcode,
    input  logic [arpc_pkg::IP_W-1:0]      ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]     mac_addr,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           hit,
    output logic [arpc_pkg::MAC_W-1:0]     mac_out,
    output logic [arpc_pkg::SLOT_W-1:0]    slot
);

    logic [arpc_pkg::IP_W-1:0]   mem_ip  [arpc_pkg::ENTRIES];
    logic [arpc_pkg::MAC_W-1:0]  mem_mac [arpc_pkg::ENTRIES];

    logic                        op_reg;
    logic [arpc_pkg::IP_W-1:0]   ip_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_reg;
    logic [arpc_pkg::CNT_W-1:0]  fill_reg;
    logic [arpc_pkg::CNT_W-1:0]  fill_next;
    logic [arpc_pkg::CNT_W-1:0]  rd_idx_reg;
    logic [arpc_pkg::CNT_W-1:0]  rd_idx_next;
    logic [arpc_pkg::IDX_W-1:0]  cmp_idx_reg;
    logic                        cmp_vld_reg;
    logic                        cmp_vld_next;
    logic [arpc_pkg::IP_W-1:0]   rd_ip_reg;
    logic [arpc_pkg::MAC_W-1:0]  rd_mac_reg;
    logic                        found_reg;
    logic [arpc_pkg::IDX_W-1:0]  found_idx_reg;
    logic [arpc_pkg::MAC_W-1:0]  found_mac_reg;
    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic                        hit_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_out_reg;
    logic [arpc_pkg::SLOT_W-1:0] slot_reg;

    logic                        issue;
    logic                        equal;
    logic                        full;
    logic                        do_write;
    logic [arpc_pkg::IDX_W-1:0]  wr_idx;

    assign issue = cmd.scan && (rd_idx_reg < fill_reg);
    assign full  = (fill_reg == arpc_pkg::CNT_W'(arpc_pkg::ENTRIES));

    always_comb
    begin
        if (op_reg == arpc_pkg::OP_ADD)
        begin
            equal = (rd_ip_reg == ip_reg) || (rd_mac_reg == mac_reg);
        end
        else
        begin
            equal = (rd_ip_reg == ip_reg);
        end
    end

    assign sts.match     = cmp_vld_reg && equal;
    assign sts.scan_done = !cmp_vld_reg && (rd_idx_reg >= fill_reg);
    assign sts.out_free  = !out_vld_reg || !rsp_stall;

    always_comb
    begin
        if (found_reg)
        begin
            wr_idx = found_idx_reg;
        end
        else if (full)
        begin
            wr_idx = '0;
        end
        else
        begin
            wr_idx = fill_reg[arpc_pkg::IDX_W-1:0];
        end
    end

    assign do_write = cmd.commit && (op_reg == arpc_pkg::OP_ADD);

    always_comb
    begin
        fill_next = fill_reg;
        if (do_write && !found_reg && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
        rd_idx_next = rd_idx_reg;
        if (cmd.load)
        begin
            rd_idx_next = '0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        cmp_vld_next = issue;
        if (cmd.commit)
        begin
            out_vld_next = 1'b1;
        end
        else
        begin
            out_vld_next = out_vld_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan && sts.match)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            ip_reg  <= ip_addr;
            mac_reg <= mac_addr;
        end
        if (issue)
        begin
            rd_ip_reg   <= mem_ip[rd_idx_reg[arpc_pkg::IDX_W-1:0]];
            rd_mac_reg  <= mem_mac[rd_idx_reg[arpc_pkg::IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[arpc_pkg::IDX_W-1:0];
        end
        if (cmd.scan && sts.match)
        begin
            found_idx_reg <= cmp_idx_reg;
            found_mac_reg <= rd_mac_reg;
        end
        if (do_write)
        begin
            mem_ip[wr_idx]  <= ip_reg;
            mem_mac[wr_idx] <= mac_reg;
        end
        if (cmd.commit)
        begin
            hit_reg <= found_reg;
            if (op_reg == arpc_pkg::OP_LOOKUP)
            begin
                mac_out_reg <= found_reg ? found_mac_reg : '0;
                slot_reg    <= found_reg ? arpc_pkg::SLOT_W'(found_idx_reg) : '0;
            end
            else
            begin
                mac_out_reg <= '0;
                slot_reg    <= arpc_pkg::SLOT_W'(wr_idx);
            end
        end
    end

    assign rsp_valid = out_vld_reg;
    assign hit       = hit_reg;
    assign mac_out   = mac_out_reg;
    assign slot      = slot_reg;

endmodule

/* src/arp_cache_table.sv */
// ============================================================================
// arp_cache_table
// Sixteen-entry ARP cache that maps IPv4 addresses to Ethernet addresses.
// ============================================================================
// A request beat carries opcode, ip_addr and mac_addr on the req channel; a
// lookup (opcode 0) returns the first filled slot whose IP matches, and an
// add (opcode 1) overwrites the first slot matching by IP or MAC, or else
// fills the next free slot, or slot 0 once the table is full.
// Every request gives one response beat on the rsp channel with hit,
// mac_out and slot.
// One request is worked on at a time. The entry memory is read one slot per
// cycle through its single registered read port, from slot 0 until the scan
// stops on a match or after the last filled slot. The next request is
// accepted in the cycle after the response is loaded.
// Reset empties the table: the fill count goes to zero and no response is
// pending. When the receiver stalls, the response holds in the output
// register; the block finishes the next request and waits for that
// register to free before loading it.
// ============================================================================
module arp_cache_table
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           opcode,
    input  logic [arpc_pkg::IP_W-1:0]      ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]     mac_addr,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           hit,
    output logic [arpc_pkg::MAC_W-1:0]     mac_out,
    output logic [arpc_pkg::SLOT_W-1:0]    slot
);

    arpc_pkg::cmd_t cmd;
    arpc_pkg::sts_t sts;

    arpc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    arpc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (opcode),
        .ip_addr   (ip_addr),
        .mac_addr  (mac_addr),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .mac_out   (mac_out),
        .slot      (slot)
    );

endmodule
